@@ rtl/core/intel_hex_record_builder_top_macros.svh @@
// ----------------------------------------------------------------------------
// Intel HEX record builder: assertion macros
// Immediate-implication and next-cycle-implication checks, clocked and
// disabled in reset. Empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_BUILDER_TOP_MACROS_SVH
`define INTEL_HEX_RECORD_BUILDER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define IHRB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ihrb: same-cycle check failed");
// next-cycle implication
`define IHRB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ihrb: next-cycle check failed");
`else
`define IHRB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define IHRB_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/ihrb_pkg.sv @@
// ----------------------------------------------------------------------------
// ihrb_pkg
// Shared types, record codes and checksum helper for the HEX record builder.
// ----------------------------------------------------------------------------
`default_nettype none

package ihrb_pkg;

    // largest data record the datapath can carry
    localparam int MAX_BYTES = 16;
    localparam int PAYLOAD_W = MAX_BYTES * 8;

    // record_type codes on the result port
    localparam logic [1:0] REC_DATA = 2'd0;
    localparam logic [1:0] REC_EXT  = 2'd1;
    localparam logic [1:0] REC_EOF  = 2'd2;

    // type codes as they enter the checksum
    localparam logic [7:0] HEX_DATA = 8'h00;
    localparam logic [7:0] HEX_EXT  = 8'h04;
    localparam logic [7:0] HEX_EOF  = 8'h01;

    localparam logic [4:0] EXT_COUNT = 5'd2;
    localparam logic [4:0] ONE_COUNT = 5'd1;
    localparam logic [7:0] EOF_CKS   = 8'hFF;

    // command queue depth
    localparam int CMD_DEPTH = 2;

    // one front-end command: up to two data records and an end marker
    typedef struct packed {
        logic                 r1_valid;
        logic [4:0]           r1_count;
        logic [31:0]          r1_start;
        logic [7:0]           r1_sum;
        logic [PAYLOAD_W-1:0] r1_payload;
        logic                 r2_valid;   // single-byte record
        logic [31:0]          r2_addr;
        logic [7:0]           r2_byte;
        logic                 eof;
    } cmd_t;

    // queue status seen by producer and consumer
    typedef struct packed {
        logic not_full;
        logic not_empty;
    } q_stat_t;

    // one result word
    typedef struct packed {
        logic [1:0]  record_type;
        logic [4:0]  byte_count;
        logic [15:0] load_offset;
        logic [63:0] payload_low;
        logic [63:0] payload_high;
        logic [7:0]  record_checksum;
        logic        last_of_run;
    } rec_t;

    // two's complement of an 8-bit byte sum
    function automatic logic [7:0] cks8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c, input logic [7:0] d,
                                        input logic [7:0] e);
        logic [7:0] s;
        s = a + b + c + d + e;
        return 8'h00 - s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ihrb_if.sv @@
// ----------------------------------------------------------------------------
// ihrb_if
// Valid/ready channels: memory locations in, HEX records out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihrb_loc_if;
    logic        valid;
    logic        ready;
    logic [31:0] location_address;
    logic        location_present;
    logic [7:0]  data_byte;
    logic        last_location;

    modport source (output valid, output location_address, output location_present,
                    output data_byte, output last_location, input ready);
    modport sink   (input valid, input location_address, input location_present,
                    input data_byte, input last_location, output ready);
endinterface

interface ihrb_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_type;
    logic [4:0]  byte_count;
    logic [15:0] load_offset;
    logic [63:0] payload_low;
    logic [63:0] payload_high;
    logic [7:0]  record_checksum;
    logic        last_of_run;

    modport source (output valid, output record_type, output byte_count,
                    output load_offset, output payload_low, output payload_high,
                    output record_checksum, output last_of_run, input ready);
    modport sink   (input valid, input record_type, input byte_count,
                    input load_offset, input payload_low, input payload_high,
                    input record_checksum, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ihrb_front.sv @@
// ----------------------------------------------------------------------------
// ihrb_front
// Accepts locations, gathers the open record and issues flush commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ihrb_front #(
    parameter int RECORD_BYTES = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    ihrb_loc_if.sink               loc,
    input  wire ihrb_pkg::q_stat_t q_stat,
    output logic                   push,
    output ihrb_pkg::cmd_t         push_cmd
);

    localparam int FILL_W = $clog2(RECORD_BYTES + 1);
    localparam int IDX_W  = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [31:0]       start_reg, start_next;
    logic [7:0]        sum_reg, sum_next;
    logic [7:0]        bytes_reg [RECORD_BYTES];

    logic              accept;
    logic              open_rec;
    logic              boundary;
    logic              use_new;
    logic [FILL_W-1:0] new_fill;
    logic [FILL_W-1:0] snap_cnt;
    logic              r1_v, r2_v;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [ihrb_pkg::PAYLOAD_W-1:0] snap_payload;

    assign loc.ready = q_stat.not_full;
    assign accept    = loc.valid && loc.ready;
    assign open_rec  = (fill_reg != '0);
    assign boundary  = loc.location_present && open_rec
                       && (loc.location_address[15:0] == 16'h0000);
    assign use_new   = loc.location_present && !boundary;
    assign new_fill  = fill_reg + FILL_W'(1);
    assign snap_cnt  = use_new ? new_fill : fill_reg;

    // snapshot lanes: stored bytes, with this word's byte when appended
    for (genvar g = 0; g < ihrb_pkg::MAX_BYTES; g++) begin : g_lane
        if (g < RECORD_BYTES) begin : g_used
            assign snap_payload[g*8 +: 8] =
                (FILL_W'(g) < snap_cnt)
                    ? ((use_new && (fill_reg == FILL_W'(g))) ? loc.data_byte
                                                             : bytes_reg[g])
                    : 8'h00;
        end else begin : g_unused
            assign snap_payload[g*8 +: 8] = 8'h00;
        end
    end

    // classify the word and work out the next record state
    always_comb
    begin
        r1_v       = 1'b0;
        r2_v       = 1'b0;
        fill_next  = fill_reg;
        start_next = start_reg;
        sum_next   = sum_reg;
        wr_en      = 1'b0;
        wr_idx     = fill_reg[IDX_W-1:0];
        if (!loc.location_present) begin
            r1_v      = open_rec;
            fill_next = '0;
            sum_next  = 8'h00;
        end else if (boundary) begin
            // old record closes, this byte opens a new one
            r1_v       = 1'b1;
            r2_v       = (RECORD_BYTES == 1) || loc.last_location;
            start_next = loc.location_address;
            fill_next  = r2_v ? '0 : FILL_W'(1);
            sum_next   = r2_v ? 8'h00 : loc.data_byte;
            wr_en      = 1'b1;
            wr_idx     = '0;
        end else begin
            r1_v       = (new_fill == FILL_W'(RECORD_BYTES)) || loc.last_location;
            start_next = open_rec ? start_reg : loc.location_address;
            fill_next  = r1_v ? '0 : new_fill;
            sum_next   = r1_v ? 8'h00 : (sum_reg + loc.data_byte);
            wr_en      = 1'b1;
        end
    end

    // command toward the queue
    always_comb
    begin
        push_cmd            = '0;
        push_cmd.r1_valid   = r1_v;
        push_cmd.r1_count   = 5'(snap_cnt);
        push_cmd.r1_start   = use_new ? (open_rec ? start_reg : loc.location_address)
                                      : start_reg;
        push_cmd.r1_sum     = use_new ? (sum_reg + loc.data_byte) : sum_reg;
        push_cmd.r1_payload = snap_payload;
        push_cmd.r2_valid   = r2_v;
        push_cmd.r2_addr    = loc.location_address;
        push_cmd.r2_byte    = loc.data_byte;
        push_cmd.eof        = loc.last_location;
    end

    assign push = accept && (r1_v || r2_v || loc.last_location);

    // record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg  <= '0;
            start_reg <= '0;
            sum_reg   <= '0;
        end else if (accept) begin
            fill_reg  <= fill_next;
            start_reg <= start_next;
            sum_reg   <= sum_next;
        end
    end

    // record bytes, no reset
    always_ff @(posedge clk)
    begin
        if (accept && wr_en) begin
            bytes_reg[wr_idx] <= loc.data_byte;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ihrb_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// ihrb_cmd_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "intel_hex_record_builder_top_macros.svh"

module ihrb_cmd_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ihrb_pkg::cmd_t    push_cmd,
    input  wire logic              pop,
    output ihrb_pkg::cmd_t         head_cmd,
    output ihrb_pkg::q_stat_t      q_stat
);

    localparam int PTR_W = $clog2(ihrb_pkg::CMD_DEPTH);
    localparam int CNT_W = $clog2(ihrb_pkg::CMD_DEPTH + 1);

    ihrb_pkg::cmd_t    entry_reg [ihrb_pkg::CMD_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign q_stat.not_full  = (count_reg != CNT_W'(ihrb_pkg::CMD_DEPTH));
    assign q_stat.not_empty = (count_reg != '0);
    assign head_cmd         = entry_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // entries
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `IHRB_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(ihrb_pkg::CMD_DEPTH))
    `IHRB_ASSERT_IMP(a_no_overflow, clk, rst_n, push, q_stat.not_full || pop)
    `IHRB_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, q_stat.not_empty)

endmodule

`default_nettype wire

@@ rtl/core/ihrb_back.sv @@
// ----------------------------------------------------------------------------
// ihrb_back
// Expands queued commands into address, data and end records, one a cycle while rec accepts them.
// ----------------------------------------------------------------------------
`default_nettype none
`include "intel_hex_record_builder_top_macros.svh"

module ihrb_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ihrb_pkg::q_stat_t q_stat,
    input  wire ihrb_pkg::cmd_t    head_cmd,
    output logic                   pop,
    ihrb_rec_if.source             rec
);

    typedef enum logic [2:0] {
        ST_EXT1,
        ST_DAT1,
        ST_EXT2,
        ST_DAT2,
        ST_EOF
    } step_t;

    step_t          phase_reg, cur_step, step_after;
    logic [15:0]    seg_reg;
    logic           out_valid_reg;
    ihrb_pkg::rec_t out_rec_reg;

    logic [15:0]    seg1, seg2, cur_seg;
    logic           en_ext1, en_dat1, en_ext2, en_dat2, en_eof, any_en;
    logic           cur_last, can_load, emit;
    ihrb_pkg::rec_t rec_next;

    assign seg1 = head_cmd.r1_start[31:16];
    assign seg2 = head_cmd.r2_addr[31:16];

    // steps still due for the head command
    assign en_ext1 = head_cmd.r1_valid && (seg1 != seg_reg) && (phase_reg <= ST_EXT1);
    assign en_dat1 = head_cmd.r1_valid && (phase_reg <= ST_DAT1);
    assign en_ext2 = head_cmd.r2_valid && (seg2 != seg_reg) && (phase_reg <= ST_EXT2);
    assign en_dat2 = head_cmd.r2_valid && (phase_reg <= ST_DAT2);
    assign en_eof  = head_cmd.eof;
    assign any_en  = en_ext1 || en_dat1 || en_ext2 || en_dat2 || en_eof;

    // pick the first due step
    always_comb
    begin
        if (en_ext1) begin
            cur_step = ST_EXT1;
        end else if (en_dat1) begin
            cur_step = ST_DAT1;
        end else if (en_ext2) begin
            cur_step = ST_EXT2;
        end else if (en_dat2) begin
            cur_step = ST_DAT2;
        end else begin
            cur_step = ST_EOF;
        end
    end

    assign cur_seg = (cur_step == ST_EXT1) ? seg1 : seg2;

    // build the record for the chosen step
    always_comb
    begin
        rec_next   = '0;
        cur_last   = 1'b0;
        step_after = ST_EXT1;
        case (cur_step)
            ST_EXT1, ST_EXT2:
            begin
                rec_next.record_type     = ihrb_pkg::REC_EXT;
                rec_next.byte_count      = ihrb_pkg::EXT_COUNT;
                rec_next.payload_low     = {48'h0, cur_seg[7:0], cur_seg[15:8]};
                rec_next.record_checksum = ihrb_pkg::cks8({3'b000, ihrb_pkg::EXT_COUNT},
                                               8'h00, ihrb_pkg::HEX_EXT,
                                               cur_seg[15:8], cur_seg[7:0]);
                step_after = (cur_step == ST_EXT1) ? ST_DAT1 : ST_DAT2;
            end
            ST_DAT1:
            begin
                rec_next.record_type     = ihrb_pkg::REC_DATA;
                rec_next.byte_count      = head_cmd.r1_count;
                rec_next.load_offset     = head_cmd.r1_start[15:0];
                rec_next.payload_low     = head_cmd.r1_payload[63:0];
                rec_next.payload_high    = head_cmd.r1_payload[127:64];
                rec_next.record_checksum = ihrb_pkg::cks8({3'b000, head_cmd.r1_count},
                                               head_cmd.r1_start[15:8],
                                               head_cmd.r1_start[7:0],
                                               ihrb_pkg::HEX_DATA, head_cmd.r1_sum);
                cur_last   = !head_cmd.r2_valid && !head_cmd.eof;
                step_after = ST_EXT2;
            end
            ST_DAT2:
            begin
                rec_next.record_type     = ihrb_pkg::REC_DATA;
                rec_next.byte_count      = ihrb_pkg::ONE_COUNT;
                rec_next.load_offset     = head_cmd.r2_addr[15:0];
                rec_next.payload_low     = {56'h0, head_cmd.r2_byte};
                rec_next.record_checksum = ihrb_pkg::cks8({3'b000, ihrb_pkg::ONE_COUNT},
                                               head_cmd.r2_addr[15:8],
                                               head_cmd.r2_addr[7:0],
                                               ihrb_pkg::HEX_DATA, head_cmd.r2_byte);
                cur_last   = !head_cmd.eof;
                step_after = ST_EOF;
            end
            default:
            begin
                rec_next.record_type     = ihrb_pkg::REC_EOF;
                rec_next.record_checksum = ihrb_pkg::EOF_CKS;
                cur_last   = 1'b1;
                step_after = ST_EXT1;
            end
        endcase
        rec_next.last_of_run = cur_last;
    end

    assign can_load = !out_valid_reg || rec.ready;
    assign emit     = q_stat.not_empty && can_load && any_en;
    assign pop      = emit && cur_last;

    // sequencer state, segment and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= ST_EXT1;
            seg_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_rec_reg   <= '0;
        end else begin
            if (emit) begin
                out_valid_reg <= 1'b1;
                out_rec_reg   <= rec_next;
                phase_reg     <= cur_last ? ST_EXT1 : step_after;
                if (cur_step == ST_EXT1 || cur_step == ST_EXT2) begin
                    seg_reg <= cur_seg;
                end
            end else if (rec.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rec.valid           = out_valid_reg;
    assign rec.record_type     = out_rec_reg.record_type;
    assign rec.byte_count      = out_rec_reg.byte_count;
    assign rec.load_offset     = out_rec_reg.load_offset;
    assign rec.payload_low     = out_rec_reg.payload_low;
    assign rec.payload_high    = out_rec_reg.payload_high;
    assign rec.record_checksum = out_rec_reg.record_checksum;
    assign rec.last_of_run     = out_rec_reg.last_of_run;

    `IHRB_ASSERT_IMP(a_work_left, clk, rst_n, q_stat.not_empty, any_en)
    `IHRB_ASSERT_IMP(a_dat2_has_byte, clk, rst_n, emit && (cur_step == ST_DAT2), head_cmd.r2_valid)
    `IHRB_ASSERT_NXT(a_seg_follows, clk, rst_n, emit && (cur_step == ST_EXT1 || cur_step == ST_EXT2), seg_reg == $past(cur_seg))

endmodule

`default_nettype wire

@@ rtl/core/intel_hex_record_builder_top.sv @@
// ----------------------------------------------------------------------------
// intel_hex_record_builder_top
// Packs a stream of memory locations into Intel HEX records (binary fields).
//
//   channel  dir  word                               handshake
//   loc      in   address, present, byte, last       valid/ready
//   rec      out  type, count, offset, payload, cks  valid/ready
//
// One location is taken per cycle while the command queue has room.
// The back-end sequencer emits one record at a time; a location yields
// up to five records, so bursts hold loc.ready low through the queue.
// First record is registered in the queue and then in the output register of rec.
// Reset clears record state and segment at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module intel_hex_record_builder_top #(
    parameter int RECORD_BYTES = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ihrb_loc_if.sink   loc,
    ihrb_rec_if.source rec
);

    ihrb_pkg::q_stat_t q_stat;
    ihrb_pkg::cmd_t    push_cmd, head_cmd;
    logic              push, pop;

    // front end: gather bytes, issue flush commands
    ihrb_front #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .loc      (loc),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // command queue
    ihrb_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    // back end: emit records
    ihrb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .head_cmd (head_cmd),
        .pop      (pop),
        .rec      (rec)
    );

endmodule

`default_nettype wire
